/* rtl/csat_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csat_pkg
// Shared types and constants of the convex polygon collision unit.
// ----------------------------------------------------------------------------
package csat_pkg;

  // Read operation issued to the vertex stores.
  typedef enum logic [1:0] {
    OP_NONE    = 2'd0,
    OP_EDGE_LO = 2'd1,
    OP_EDGE_HI = 2'd2,
    OP_PROJ    = 2'd3
  } rd_op_t;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic   wr_en;
    logic   wr_poly;
    logic   rd_poly;
    rd_op_t rd_op;
    logic   proj_first;
  } dp_cmd_t;

  // Length of the drain phase after the last projection read, before the extremes are compared.
  localparam int DP_DRAIN_CYCLES = 3;

endpackage

`default_nettype wire

/* rtl/csat_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csat_datapath
// Vertex stores, axis builder, projection pipeline and interval compare.
// ----------------------------------------------------------------------------
module csat_datapath #(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS   = 16
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  csat_pkg::dp_cmd_t                    cmd,
  input  wire  [$clog2(MAX_VERTICES)-1:0]      wr_addr,
  input  wire  [$clog2(MAX_VERTICES)-1:0]      rd_addr,
  input  wire  signed [COORD_BITS-1:0]         vx,
  input  wire  signed [COORD_BITS-1:0]         vy,
  output logic                                 separated
);
  import csat_pkg::*;

  localparam int VW = 2 * COORD_BITS;
  localparam int EW = COORD_BITS + 1;
  localparam int PW = 2 * COORD_BITS + 1;
  localparam int DW = 2 * COORD_BITS + 2;

  logic [VW-1:0] mem_a [MAX_VERTICES];
  logic [VW-1:0] mem_b [MAX_VERTICES];
  logic [VW-1:0] rdata_a;
  logic [VW-1:0] rdata_b;

  rd_op_t op_d1;
  logic   poly_d1;
  logic   first_d1;

  logic [VW-1:0]               rd_word;
  logic signed [COORD_BITS-1:0] px;
  logic signed [COORD_BITS-1:0] py;

  logic signed [COORD_BITS-1:0] pi_x;
  logic signed [COORD_BITS-1:0] pi_y;
  logic signed [EW-1:0]         ax;
  logic signed [EW-1:0]         ay;

  logic signed [PW-1:0] prod_x;
  logic signed [PW-1:0] prod_y;
  logic                 v2;
  logic                 poly_d2;
  logic                 first_d2;

  logic signed [DW-1:0] dot;
  logic                 v3;
  logic                 poly_d3;
  logic                 first_d3;

  logic signed [DW-1:0] a_lo;
  logic signed [DW-1:0] a_hi;
  logic signed [DW-1:0] b_lo;
  logic signed [DW-1:0] b_hi;

  // Vertex stores: one write and one registered read port each.
  always_ff @(posedge clk) begin
    if (cmd.wr_en && !cmd.wr_poly) begin
      mem_a[wr_addr] <= {vx, vy};
    end
    if (cmd.wr_en && cmd.wr_poly) begin
      mem_b[wr_addr] <= {vx, vy};
    end
    rdata_a <= mem_a[rd_addr];
    rdata_b <= mem_b[rd_addr];
  end

  always_comb begin
    rd_word = poly_d1 ? rdata_b : rdata_a;
    px      = signed'(rd_word[VW-1:COORD_BITS]);
    py      = signed'(rd_word[COORD_BITS-1:0]);
  end

  // Pipeline control tags.
  always_ff @(posedge clk) begin
    if (rst) begin
      op_d1 <= OP_NONE;
      v2    <= 1'b0;
      v3    <= 1'b0;
    end else begin
      op_d1 <= cmd.rd_op;
      v2    <= (op_d1 == OP_PROJ);
      v3    <= v2;
    end
  end

  // Edge capture, axis, products, dot product and running extremes.
  always_ff @(posedge clk) begin
    poly_d1  <= cmd.rd_poly;
    first_d1 <= cmd.proj_first;
    poly_d2  <= poly_d1;
    first_d2 <= first_d1;
    poly_d3  <= poly_d2;
    first_d3 <= first_d2;

    if (op_d1 == OP_EDGE_LO) begin
      pi_x <= px;
      pi_y <= py;
    end
    if (op_d1 == OP_EDGE_HI) begin
      // Axis (-dy, dx) of the edge from p[i] to p[j].
      ax <= EW'(pi_y) - EW'(py);
      ay <= EW'(px) - EW'(pi_x);
    end

    prod_x <= PW'(px) * PW'(ax);
    prod_y <= PW'(py) * PW'(ay);
    dot    <= DW'(prod_x) + DW'(prod_y);

    if (v3 && !poly_d3) begin
      if (first_d3 || dot < a_lo) a_lo <= dot;
      if (first_d3 || dot > a_hi) a_hi <= dot;
    end
    if (v3 && poly_d3) begin
      if (first_d3 || dot < b_lo) b_lo <= dot;
      if (first_d3 || dot > b_hi) b_hi <= dot;
    end
  end

  // Strict gap between the two intervals.
  assign separated = (a_hi < b_lo) || (b_hi < a_lo);

endmodule

`default_nettype wire

/* rtl/csat_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csat_ctrl
// Loads vertex counts, sequences edges and projections, holds the result.
// ----------------------------------------------------------------------------
module csat_ctrl #(
  parameter int MAX_VERTICES = 64
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  item_valid,
  output logic                                 item_stall,
  input  wire                                  kind,
  input  wire                                  last,
  output logic                                 result_valid,
  input  wire                                  result_stall,
  output logic                                 collides,
  output logic                                 overflow,
  output csat_pkg::dp_cmd_t                    cmd,
  output logic [$clog2(MAX_VERTICES)-1:0]      wr_addr,
  output logic [$clog2(MAX_VERTICES)-1:0]      rd_addr,
  input  wire                                  separated
);
  import csat_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam logic [1:0] DRAIN_LAST = 2'(DP_DRAIN_CYCLES - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_EDGE_LO,
    S_EDGE_HI,
    S_PROJ,
    S_DRAIN,
    S_CHECK,
    S_DONE
  } state_t;

  state_t        state;
  logic [CW-1:0] first_count;
  logic [CW-1:0] second_count;
  logic          ovf;
  logic          res_collides;
  logic          edge_poly;
  logic [AW-1:0] edge_idx;
  logic [1:0]    drain;
  rd_op_t        rd_op;
  logic          rd_poly;
  logic          proj_first;

  logic          accept;
  logic          a_full;
  logic          b_full;
  logic [CW-1:0] edge_cnt;
  logic [CW-1:0] edge_inc;
  logic [AW-1:0] edge_j;
  logic [CW-1:0] vert_cnt;
  logic [CW-1:0] vert_inc;

  always_comb begin
    accept   = item_valid && (state == S_IDLE);
    a_full   = (first_count == CW'(MAX_VERTICES));
    b_full   = (second_count == CW'(MAX_VERTICES));
    edge_cnt = edge_poly ? second_count : first_count;
    edge_inc = CW'(edge_idx) + CW'(1);
    edge_j   = (edge_inc == edge_cnt) ? '0 : edge_inc[AW-1:0];
    vert_cnt = rd_poly ? second_count : first_count;
    vert_inc = CW'(rd_addr) + CW'(1);

    item_stall = (state != S_IDLE);
    wr_addr    = kind ? second_count[AW-1:0] : first_count[AW-1:0];

    cmd.wr_en      = accept && !(kind ? b_full : a_full);
    cmd.wr_poly    = kind;
    cmd.rd_poly    = rd_poly;
    cmd.rd_op      = rd_op;
    cmd.proj_first = proj_first;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      rd_op        <= OP_NONE;
      first_count  <= '0;
      second_count <= '0;
      ovf          <= 1'b0;
    end else begin
      // Drop a taken result; S_DONE reloads the register on its own.
      if (result_valid && !result_stall && state != S_DONE) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (!kind) begin
              if (!a_full) first_count <= first_count + CW'(1);
              else         ovf <= 1'b1;
            end else begin
              if (!b_full) second_count <= second_count + CW'(1);
              else         ovf <= 1'b1;
            end
            if (last) state <= S_START;
          end
        end
        S_START: begin
          if (first_count == '0 || second_count == '0) begin
            res_collides <= 1'b0;
            state        <= S_DONE;
          end else begin
            edge_poly <= 1'b0;
            edge_idx  <= '0;
            rd_poly   <= 1'b0;
            rd_addr   <= '0;
            rd_op     <= OP_EDGE_LO;
            state     <= S_EDGE_LO;
          end
        end
        S_EDGE_LO: begin
          rd_op   <= OP_EDGE_HI;
          rd_addr <= edge_j;
          state   <= S_EDGE_HI;
        end
        S_EDGE_HI: begin
          rd_op      <= OP_PROJ;
          rd_poly    <= 1'b0;
          rd_addr    <= '0;
          proj_first <= 1'b1;
          state      <= S_PROJ;
        end
        S_PROJ: begin
          // Mark the first read of polygon B when A runs out.
          proj_first <= (vert_inc == vert_cnt) && !rd_poly;
          if (vert_inc == vert_cnt) begin
            if (!rd_poly) begin
              rd_poly <= 1'b1;
              rd_addr <= '0;
            end else begin
              rd_op <= OP_NONE;
              drain <= '0;
              state <= S_DRAIN;
            end
          end else begin
            rd_addr <= vert_inc[AW-1:0];
          end
        end
        S_DRAIN: begin
          drain <= drain + 2'd1;
          if (drain == DRAIN_LAST) state <= S_CHECK;
        end
        S_CHECK: begin
          if (separated) begin
            res_collides <= 1'b0;
            state        <= S_DONE;
          end else if (edge_inc == edge_cnt) begin
            if (!edge_poly) begin
              edge_poly <= 1'b1;
              edge_idx  <= '0;
              rd_poly   <= 1'b1;
              rd_addr   <= '0;
              rd_op     <= OP_EDGE_LO;
              state     <= S_EDGE_LO;
            end else begin
              res_collides <= 1'b1;
              state        <= S_DONE;
            end
          end else begin
            edge_idx <= edge_inc[AW-1:0];
            rd_poly  <= edge_poly;
            rd_addr  <= edge_inc[AW-1:0];
            rd_op    <= OP_EDGE_LO;
            state    <= S_EDGE_LO;
          end
        end
        S_DONE: begin
          if (!result_valid || !result_stall) begin
            result_valid <= 1'b1;
            collides     <= res_collides;
            overflow     <= ovf;
            ovf          <= 1'b0;
            first_count  <= '0;
            second_count <= '0;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/convex_polygon_sat_collision_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// convex_polygon_sat_collision_unit
// Separating axis collision test for two convex polygons in the plane.
// ----------------------------------------------------------------------------
// Vertices arrive one per transaction, one per cycle while the unit is idle:
// first polygon A (kind 0), then polygon B (kind 1), up to MAX_VERTICES each;
// extra vertices are dropped and reported through overflow. The transaction
// with last set starts the test, and input stalls until it ends. Every edge
// of A and of B gives an axis (-dy, dx); both polygons are projected onto it
// with exact integer dot products, and a strict gap on any axis ends the test
// with collides = 0, so touching shapes collide. An empty polygon gives
// collides = 0. The test tries at most nA + nB axes, nA and nB being the
// stored vertex counts. Each vertex store has one read port, so one
// projection enters the four-stage multiply-add pipeline per cycle, and
// each axis waits for that pipeline to drain before its intervals are
// compared. The result sits in an output register; a new vertex load may
// begin while it waits to be taken.
// ----------------------------------------------------------------------------
module convex_polygon_sat_collision_unit #(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS   = 16
) (
  input  wire                          clk,
  input  wire                          rst,
  // vertex channel
  input  wire                          item_valid,
  output logic                         item_stall,
  input  wire                          kind,
  input  wire  signed [COORD_BITS-1:0] vx,
  input  wire  signed [COORD_BITS-1:0] vy,
  input  wire                          last,
  // result channel
  output logic                         result_valid,
  input  wire                          result_stall,
  output logic                         collides,
  output logic                         overflow
);
  import csat_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);

  dp_cmd_t       cmd;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic          separated;

  // Sequence the load, the edge walk and the result handshake.
  csat_ctrl #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .kind         (kind),
    .last         (last),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .collides     (collides),
    .overflow     (overflow),
    .cmd          (cmd),
    .wr_addr      (wr_addr),
    .rd_addr      (rd_addr),
    .separated    (separated)
  );

  // Hold the vertices, build each axis and project both polygons onto it.
  csat_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .wr_addr   (wr_addr),
    .rd_addr   (rd_addr),
    .vx        (vx),
    .vy        (vy),
    .separated (separated)
  );

endmodule

`default_nettype wire

/* rtl/csat_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csat_checker
// Port-level checks of the collision unit, bound to its top level.
// ----------------------------------------------------------------------------
module csat_checker (
  input wire clk,
  input wire rst,
  input wire item_valid,
  input wire item_stall,
  input wire last,
  input wire result_valid,
  input wire result_stall,
  input wire collides,
  input wire overflow
);

  // Reset leaves no result pending.
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  // A vertex with last starts the test, so the next vertex must wait.
  a_last_blocks: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && last |=> item_stall)
    else $error("input taken right after a last vertex");

  // A new result appears only at the end of a test, while input is held.
  a_result_from_test: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(item_stall))
    else $error("result raised while the unit was idle");

  // A stalled result transaction holds its payload.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=>
      result_valid && $stable(collides) && $stable(overflow))
    else $error("stalled result changed");

endmodule

bind convex_polygon_sat_collision_unit csat_checker u_csat_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .last         (last),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .collides     (collides),
  .overflow     (overflow)
);

`default_nettype wire
